### sv/crc8_length_frame_receiver_core_macros.svh
// Assertion macros for the frame receiver modules; only crc8lfr_frame_fsm uses them.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef CRC8_LENGTH_FRAME_RECEIVER_CORE_MACROS_SVH
`define CRC8_LENGTH_FRAME_RECEIVER_CORE_MACROS_SVH
`ifndef SYNTH
`define CRC8LFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("crc8lfr assertion failed");
`define CRC8LFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crc8lfr implication failed");
`define CRC8LFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crc8lfr next-cycle check failed");
`else
`define CRC8LFR_ASSERT(lbl, prop)
`define CRC8LFR_ASSERT_IMP(lbl, ante, cons)
`define CRC8LFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/crc8lfr_pkg.sv
// Types, constants and the CRC-8 byte update for the frame receiver.
// No dependencies.
package crc8lfr_pkg;

  localparam int unsigned MaxFrame    = 256;
  localparam int unsigned HeaderBytes = 3;
  localparam int unsigned LenW        = 16;
  localparam int unsigned TotalW      = 17;
  localparam logic [7:0]  SofByte     = 8'hAA;
  localparam logic [7:0]  CrcPoly     = 8'h31;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_CMD     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KIND_IGNORED = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_COMMAND = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_CHECK   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_GOOD     = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_BADLEN   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] byte_out;
    kind_e      kind;
    logic       frame_end;
    status_e    status;
  } result_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### sv/crc8lfr_if.sv
// Valid/ready channel interfaces for received bytes and tagged results.
// No package dependency.
interface crc8lfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crc8lfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [2:0] byte_kind;
  logic       frame_end;
  logic [1:0] frame_status;
  modport source (output valid, output byte_out, output byte_kind, output frame_end,
                  output frame_status, input ready);
  modport sink (input valid, input byte_out, input byte_kind, input frame_end,
                input frame_status, output ready);
endinterface

### sv/crc8lfr_in_stage.sv
// Input register: captures one received byte per transaction.
// Depends on crc8lfr_in_if.
module crc8lfr_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  crc8lfr_in_if.sink    rx_i,
  input  logic          take_i,
  output logic          valid_o,
  output logic [7:0]    byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign rx_i.ready = !valid_q || take_i;
  assign valid_d    = rx_i.ready ? rx_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### sv/crc8lfr_frame_fsm.sv
// Frame parser: phase, length and CRC state, and the per-byte result.
// Depends on crc8lfr_pkg and the assertion macro header.
`include "crc8_length_frame_receiver_core_macros.svh"

module crc8lfr_frame_fsm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output crc8lfr_pkg::result_t  res_o
);

  crc8lfr_pkg::phase_e phase_q, phase_d;
  logic [7:0]          len_hi_q, len_hi_d;
  logic [15:0]         left_q, left_d;
  logic [7:0]          crc_q, crc_d;

  logic [15:0] len;
  logic [16:0] total;
  logic        len_bad;
  logic [15:0] left_dec;

  assign len      = {len_hi_q, byte_i};
  assign total    = {1'b0, len} + crc8lfr_pkg::TotalW'(crc8lfr_pkg::HeaderBytes);
  assign len_bad  = (len < 16'd2) ||
                    (total > crc8lfr_pkg::TotalW'(crc8lfr_pkg::MaxFrame));
  assign left_dec = (left_q != '0) ? left_q - 16'd1 : left_q;

  always_comb begin
    phase_d  = phase_q;
    len_hi_d = len_hi_q;
    left_d   = left_q;
    crc_d    = crc_q;
    case (phase_q)
      crc8lfr_pkg::PH_LEN_HI: begin
        len_hi_d = byte_i;
        phase_d  = crc8lfr_pkg::PH_LEN_LO;
      end
      crc8lfr_pkg::PH_LEN_LO: begin
        if (len_bad) begin
          phase_d = crc8lfr_pkg::PH_HUNT;
        end else begin
          left_d  = len;
          crc_d   = '0;
          phase_d = crc8lfr_pkg::PH_CMD;
        end
      end
      crc8lfr_pkg::PH_CMD, crc8lfr_pkg::PH_PAYLOAD: begin
        crc_d   = crc8lfr_pkg::crc8_feed(crc_q, byte_i);
        left_d  = left_dec;
        phase_d = (left_dec <= 16'd1) ? crc8lfr_pkg::PH_CHECK : crc8lfr_pkg::PH_PAYLOAD;
      end
      crc8lfr_pkg::PH_CHECK: begin
        left_d  = '0;
        phase_d = crc8lfr_pkg::PH_HUNT;
      end
      default: begin
        phase_d = (byte_i == crc8lfr_pkg::SofByte) ? crc8lfr_pkg::PH_LEN_HI
                                                   : crc8lfr_pkg::PH_HUNT;
      end
    endcase
  end

  always_comb begin
    res_o.byte_out  = byte_i;
    res_o.kind      = crc8lfr_pkg::KIND_IGNORED;
    res_o.frame_end = 1'b0;
    res_o.status    = crc8lfr_pkg::ST_BUSY;
    case (phase_q)
      crc8lfr_pkg::PH_LEN_HI: begin
        res_o.kind = crc8lfr_pkg::KIND_HEADER;
      end
      crc8lfr_pkg::PH_LEN_LO: begin
        res_o.kind = crc8lfr_pkg::KIND_HEADER;
        if (len_bad) begin
          res_o.frame_end = 1'b1;
          res_o.status    = crc8lfr_pkg::ST_BADLEN;
        end
      end
      crc8lfr_pkg::PH_CMD: begin
        res_o.kind = crc8lfr_pkg::KIND_COMMAND;
      end
      crc8lfr_pkg::PH_PAYLOAD: begin
        res_o.kind = crc8lfr_pkg::KIND_PAYLOAD;
      end
      crc8lfr_pkg::PH_CHECK: begin
        res_o.kind      = crc8lfr_pkg::KIND_CHECK;
        res_o.frame_end = 1'b1;
        res_o.status    = (crc_q == byte_i) ? crc8lfr_pkg::ST_GOOD : crc8lfr_pkg::ST_MISMATCH;
      end
      default: begin
        if (byte_i == crc8lfr_pkg::SofByte) begin
          res_o.kind = crc8lfr_pkg::KIND_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= crc8lfr_pkg::PH_HUNT;
      len_hi_q <= '0;
      left_q   <= '0;
      crc_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
      crc_q    <= crc_d;
    end
  end

  `CRC8LFR_ASSERT_NEXT(a_check_then_hunt, step_i && (phase_q == crc8lfr_pkg::PH_CHECK), phase_q == crc8lfr_pkg::PH_HUNT)
  `CRC8LFR_ASSERT_NEXT(a_badlen_then_hunt, step_i && (res_o.status == crc8lfr_pkg::ST_BADLEN), phase_q == crc8lfr_pkg::PH_HUNT)
  `CRC8LFR_ASSERT_IMP(a_body_has_check_left, (phase_q == crc8lfr_pkg::PH_CMD) || (phase_q == crc8lfr_pkg::PH_PAYLOAD), left_q >= 16'd2)
  `CRC8LFR_ASSERT(a_end_iff_status, res_o.frame_end == (res_o.status != crc8lfr_pkg::ST_BUSY))

endmodule

### sv/crc8lfr_out_stage.sv
// Result register: holds one tagged byte until the sink takes it.
// Depends on crc8lfr_pkg and crc8lfr_out_if.
module crc8lfr_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  crc8lfr_pkg::result_t  res_i,
  output logic                  ready_o,
  crc8lfr_out_if.source         res_o
);

  logic                 valid_q, valid_d;
  crc8lfr_pkg::result_t data_q;

  assign ready_o = !valid_q || res_o.ready;
  assign valid_d = ready_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.byte_out     = data_q.byte_out;
  assign res_o.byte_kind    = data_q.kind;
  assign res_o.frame_end    = data_q.frame_end;
  assign res_o.frame_status = data_q.status;

endmodule

### sv/crc8_length_frame_receiver_core.sv
// Top level of the CRC-8 length-prefixed frame receiver.
// Depends on crc8lfr_pkg, crc8lfr_if and the three stage modules.
//
// rx_i carries one received byte per transaction. res_o returns exactly one
// result per byte: the byte itself, its kind (ignored, header, command,
// payload, check), a frame-end flag and the frame status (in progress, good,
// check mismatch, bad length). Frames are 0xAA, a big-endian 16-bit length
// counting command, payload and check bytes, then those bytes. CRC-8 with
// polynomial 0x31, init 0, MSB first runs over command and payload.
// An accepted byte passes from the input register through the parser into the
// result register, which offers it on res_o. Throughput: one byte per cycle
// while the sink does not stall, set by the input register, the combinational
// parser step with its unrolled CRC update, and the result register.
// Reset empties both registers and puts the parser in start-byte hunting.
// When the sink stalls, the result register holds its transaction, one more
// byte waits in the input register, and rx_i.ready then drops until the
// sink takes the result.
module crc8_length_frame_receiver_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  crc8lfr_in_if.sink    rx_i,
  crc8lfr_out_if.source res_o
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s2_ready;
  logic                 step;
  crc8lfr_pkg::result_t res;

  assign step = s1_valid && s2_ready;

  crc8lfr_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (step),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  crc8lfr_frame_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte),
    .res_o  (res)
  );

  crc8lfr_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (res),
    .ready_o (s2_ready),
    .res_o   (res_o)
  );

endmodule
